// ===== src/dof_pkg.sv =====
package dof_pkg;

  localparam int DefMaxAreaBytes = 512;

  localparam logic [7:0] CodePad      = 8'd0;
  localparam logic [7:0] CodeEnd      = 8'd255;
  localparam logic [7:0] CodeOverload = 8'd52;
  localparam logic [7:0] WantedReset  = 8'd53;

  localparam logic [1:0] RegionOptions = 2'd0;
  localparam logic [1:0] RegionFile    = 2'd1;
  localparam logic [1:0] RegionSname   = 2'd2;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_SKIP  = 2'd2,
    PH_MATCH = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOTFOUND  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] opt_byte;
    logic [1:0] region;
    logic       region_last;
    logic       packet_last;
  } item_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] skip_left;
    logic [7:0] rec_code;
    logic       ovl_pending;
    logic [1:0] overload_bits;
    logic       search_done;
    status_e    held_status;
    logic [1:0] held_region;
    logic [8:0] held_offset;
    logic [7:0] held_length;
  } state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] found_region;
    logic [8:0] data_offset;
    logic [7:0] data_length;
  } result_t;

  localparam state_t StateReset = '{
    phase:         PH_CODE,
    skip_left:     8'd0,
    rec_code:      8'd0,
    ovl_pending:   1'b0,
    overload_bits: 2'd0,
    search_done:   1'b0,
    held_status:   ST_NOTFOUND,
    held_region:   RegionOptions,
    held_offset:   9'd0,
    held_length:   8'd0
  };

  function automatic state_t finish(state_t s, status_e st);
    state_t r;
    r = s;
    r.search_done = 1'b1;
    r.held_status = st;
    if (st != ST_FOUND) begin
      r.held_region = RegionOptions;
      r.held_offset = 9'd0;
      r.held_length = 8'd0;
    end
    return r;
  endfunction

endpackage

// ===== src/dof_cfg_regs.sv =====
module dof_cfg_regs
  import dof_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  wanted_code_o
);

  logic [7:0] wanted_code_q;
  logic [7:0] wanted_code_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  always_comb begin
    wanted_code_d = wanted_code_q;
    if (wr_en) begin
      wanted_code_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_code_q <= WantedReset;
    end else begin
      wanted_code_q <= wanted_code_d;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == 1'b0) begin
      prdata = {24'd0, wanted_code_q};
    end
  end

  assign wanted_code_o = wanted_code_q;

endmodule

// ===== src/dof_parser.sv =====
module dof_parser
  import dof_pkg::*;
#(
  parameter int MAX_AREA_BYTES = DefMaxAreaBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  item_t      item_i,
  input  logic [7:0] wanted_code_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int OffW = $clog2(MAX_AREA_BYTES + 1);
  localparam logic [OffW-1:0] OffLast = OffW'(MAX_AREA_BYTES - 1);

  state_t          st_q;
  state_t          st_d;
  logic [OffW-1:0] offset_q;
  logic [OffW-1:0] offset_d;
  logic [OffW-1:0] off_inc;
  logic [OffW+8:0] off_ext;
  logic            last;
  logic            match;
  logic [7:0]      b;
  logic [7:0]      skip_dec;

  assign b        = item_i.opt_byte;
  assign off_inc  = offset_q + OffW'(1);
  assign off_ext  = {9'd0, off_inc};
  assign last     = item_i.region_last || (offset_q >= OffLast);
  assign match    = (st_q.rec_code == wanted_code_i);
  assign skip_dec = (st_q.skip_left != 8'd0) ? st_q.skip_left - 8'd1 : 8'd0;

  always_comb begin
    st_d        = st_q;
    offset_d    = offset_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire_i) begin
      if (!st_q.search_done && item_i.region == st_q.held_region) begin
        offset_d = off_inc;
        case (st_q.phase)
          PH_CODE: begin
            if (b == CodeEnd) begin
              st_d.phase = PH_CODE;
              offset_d   = '0;
              if (st_q.held_region == RegionOptions && st_q.overload_bits[0]) begin
                st_d.held_region = RegionFile;
              end else if (st_q.held_region != RegionSname && st_q.overload_bits[1]) begin
                st_d.held_region = RegionSname;
              end else begin
                st_d = finish(st_d, ST_NOTFOUND);
              end
            end else begin
              if (b != CodePad) begin
                st_d.rec_code = b;
                st_d.phase    = PH_LEN;
              end
              if (last) begin
                st_d = finish(st_d, ST_MALFORMED);
              end
            end
          end
          PH_LEN: begin
            if (match) begin
              st_d.held_offset = off_ext[8:0];
              st_d.held_length = b;
            end
            if (b == 8'd0) begin
              if (match) begin
                st_d = finish(st_d, ST_FOUND);
              end else if (last) begin
                st_d = finish(st_d, ST_MALFORMED);
              end else begin
                st_d.phase = PH_CODE;
              end
            end else begin
              st_d.skip_left   = b;
              st_d.ovl_pending = !match && (st_q.rec_code == CodeOverload);
              st_d.phase       = match ? PH_MATCH : PH_SKIP;
              if (last) begin
                st_d = finish(st_d, ST_MALFORMED);
              end
            end
          end
          default: begin
            if (st_q.ovl_pending) begin
              st_d.overload_bits = st_q.overload_bits | b[1:0];
              st_d.ovl_pending   = 1'b0;
            end
            st_d.skip_left = skip_dec;
            if (skip_dec == 8'd0) begin
              if (st_q.phase == PH_MATCH) begin
                st_d = finish(st_d, ST_FOUND);
              end else if (last) begin
                st_d = finish(st_d, ST_MALFORMED);
              end else begin
                st_d.phase = PH_CODE;
              end
            end else if (last) begin
              st_d = finish(st_d, ST_MALFORMED);
            end
          end
        endcase
      end
      if (item_i.packet_last) begin
        if (!st_d.search_done) begin
          st_d = finish(st_d, ST_MALFORMED);
        end
        res_valid_o        = 1'b1;
        res_o.status       = st_d.held_status;
        res_o.found_region = st_d.held_region;
        res_o.data_offset  = st_d.held_offset;
        res_o.data_length  = st_d.held_length;
        st_d               = StateReset;
        offset_d           = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StateReset;
      offset_q <= '0;
    end else begin
      st_q     <= st_d;
      offset_q <= offset_d;
    end
  end

endmodule

// ===== src/dof_out_reg.sv =====
module dof_out_reg
  import dof_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q;
  logic    valid_d;
  result_t res_q;
  result_t res_d;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== src/dhcp_option_find.sv =====
// DHCP option search. Bytes of the option areas stream in one per transfer,
// in search order (options, then file, then sname), with the area number and
// an end-of-area flag in tuser and the end of the message on tlast. The block
// takes one byte every cycle: a byte passes an input register, then a single
// parser update, and the result for a message is held in the output register
// until taken. Input stalls only while a message-final byte waits on a full
// output register. The result carries status (found, not found, malformed),
// the area of the match, the offset of its first data byte within that area
// and its length byte. The code searched for is the register at address 0
// (reset value 53).
module dhcp_option_find
  import dof_pkg::*;
#(
  parameter int MAX_AREA_BYTES = DefMaxAreaBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] opt_byte
  input  logic [7:0]  s_axis_tdata,
  // [1:0] region, [2] region_last
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [3:2] found_region, [12:4] data_offset, [20:13] data_length
  output logic [23:0] m_axis_tdata
);

  logic       s1_valid_q;
  logic       s1_valid_d;
  item_t      s1_item_q;
  item_t      s1_item_d;
  logic       s1_fire;
  logic       in_fire;
  logic       out_free;
  logic       res_valid;
  result_t    res;
  result_t    out_res;
  logic [7:0] wanted_code;

  dof_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .wanted_code_o (wanted_code)
  );

  assign s1_fire       = s1_valid_q && (!s1_item_q.packet_last || out_free);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_item_d  = s1_item_q;
    if (in_fire) begin
      s1_valid_d            = 1'b1;
      s1_item_d.opt_byte    = s_axis_tdata;
      s1_item_d.region      = s_axis_tuser[1:0];
      s1_item_d.region_last = s_axis_tuser[2];
      s1_item_d.packet_last = s_axis_tlast;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= s1_item_d;
  end

  dof_parser #(
    .MAX_AREA_BYTES (MAX_AREA_BYTES)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (s1_fire),
    .item_i        (s1_item_q),
    .wanted_code_i (wanted_code),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  dof_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {3'd0, out_res.data_length, out_res.data_offset,
                         out_res.found_region, out_res.status};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import dof_pkg::*;

  localparam logic [2:0] WantedAddr = 3'd0;
  localparam int HoldCycles = 80;
  localparam int QuietLimit = 2000;
  localparam int PhaseBytes = 125;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] opt_byte
  logic [7:0]  s_axis_tdata = '0;
  // [1:0] region, [2] region_last
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [1:0] status, [3:2] found_region, [12:4] data_offset, [20:13] data_length
  logic [23:0] m_axis_tdata;

  dhcp_option_find i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  item_t       tx_bytes[$];
  item_t       msg_q[$];
  logic [7:0]  area_q[$];
  result_t     pending_answers[$];
  int          queued_bytes;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int unsigned src_gap_max = 5;
  int unsigned sink_gap_max = 5;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;

  // Search state; area_sel is the area being walked until the search ends,
  // then the area of the match (the options area when there is no match).
  logic [7:0]  want_code;
  phase_e      walk_phase;
  logic [8:0]  skip_cnt;
  int          area_pos;
  logic [1:0]  ovl_bits;
  bit          search_over;
  status_e     hit_status;
  logic [1:0]  area_sel;
  logic [8:0]  hit_offset;
  logic [7:0]  hit_length;
  logic [7:0]  cur_code;
  bit          ovl_wait;

  task automatic restart_search();
    walk_phase = PH_CODE;
    skip_cnt = '0;
    area_pos = 0;
    ovl_bits = '0;
    search_over = 1'b0;
    hit_status = ST_NOTFOUND;
    area_sel = RegionOptions;
    hit_offset = '0;
    hit_length = '0;
    cur_code = '0;
    ovl_wait = 1'b0;
  endtask

  task automatic settle(input status_e st);
    search_over = 1'b1;
    hit_status = st;
    if (st != ST_FOUND) begin
      area_sel = RegionOptions;
      hit_offset = '0;
      hit_length = '0;
    end
  endtask

  task automatic close_area();
    walk_phase = PH_CODE;
    area_pos = 0;
    if (area_sel == RegionOptions && ovl_bits[0]) begin
      area_sel = RegionFile;
    end else if (area_sel <= RegionFile && ovl_bits[1]) begin
      area_sel = RegionSname;
    end else begin
      settle(ST_NOTFOUND);
    end
  endtask

  task automatic walk_byte(input logic [7:0] b, input bit at_end);
    int pos;
    bit last;
    bit hit;
    pos = area_pos;
    area_pos = pos + 1;
    last = at_end || (pos + 1 >= DefMaxAreaBytes);
    case (walk_phase)
      PH_CODE: begin
        if (b == CodeEnd) begin
          close_area();
        end else begin
          if (b != CodePad) begin
            cur_code = b;
            walk_phase = PH_LEN;
          end
          if (last) settle(ST_MALFORMED);
        end
      end
      PH_LEN: begin
        hit = (cur_code == want_code);
        if (hit) begin
          hit_offset = 9'(pos + 1);
          hit_length = b;
        end
        if (b == 8'd0) begin
          if (hit) settle(ST_FOUND);
          else if (last) settle(ST_MALFORMED);
          else walk_phase = PH_CODE;
        end else begin
          skip_cnt = {1'b0, b};
          ovl_wait = !hit && cur_code == CodeOverload;
          walk_phase = hit ? PH_MATCH : PH_SKIP;
          if (last) settle(ST_MALFORMED);
        end
      end
      default: begin
        if (ovl_wait) begin
          ovl_bits = ovl_bits | b[1:0];
          ovl_wait = 1'b0;
        end
        if (skip_cnt != 9'd0) skip_cnt = skip_cnt - 9'd1;
        if (skip_cnt == 9'd0) begin
          if (walk_phase == PH_MATCH) settle(ST_FOUND);
          else if (last) settle(ST_MALFORMED);
          else walk_phase = PH_CODE;
        end else if (last) begin
          settle(ST_MALFORMED);
        end
      end
    endcase
  endtask

  task automatic track_byte(input logic [7:0] b, input logic [1:0] rgn, input bit rlast,
                            input bit plast);
    result_t r;
    if (!search_over && rgn == area_sel) walk_byte(b, rlast);
    if (plast) begin
      if (!search_over) settle(ST_MALFORMED);
      r.status = hit_status;
      r.found_region = area_sel;
      r.data_offset = hit_offset;
      r.data_length = hit_length;
      pending_answers.push_back(r);
      restart_search();
    end
  endtask

  task automatic check_answer(input logic [23:0] bus);
    result_t want;
    if (pending_answers.size() == 0) begin
      $error("result transfer with nothing pending: tdata %h", bus);
      mismatches++;
    end else begin
      want = pending_answers.pop_front();
      if (bus[1:0] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, bus[1:0]);
        mismatches++;
      end
      if (bus[3:2] !== want.found_region) begin
        $error("found_region: expected %0d, got %0d", want.found_region, bus[3:2]);
        mismatches++;
      end
      if (bus[12:4] !== want.data_offset) begin
        $error("data_offset: expected %0d, got %0d", want.data_offset, bus[12:4]);
        mismatches++;
      end
      if (bus[20:13] !== want.data_length) begin
        $error("data_length: expected %0d, got %0d", want.data_length, bus[20:13]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : source_side
    item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_byte(s_axis_tdata, s_axis_tuser[1:0], s_axis_tuser[2], s_axis_tlast);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          it = tx_bytes.pop_front();
          s_axis_tdata <= it.opt_byte;
          s_axis_tuser <= {it.region_last, it.region};
          s_axis_tlast <= it.packet_last;
          s_axis_tvalid <= 1'b1;
          gap_left <= $urandom_range(0, src_gap_max);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : sink_side
    int unsigned pause;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_answer(m_axis_tdata);
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        pause = $urandom_range(0, sink_gap_max);
        stall_left <= pause;
        m_axis_tready <= (pause == 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= (stall_left == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("FAIL dhcp_option_find");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic apb_cycle(input bit wr, input logic [7:0] value, output logic [31:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= WantedAddr;
    pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_wanted_code(input logic [7:0] value);
    logic [31:0] rdata;
    apb_cycle(1'b1, value, rdata);
    want_code = value;
    apb_cycle(1'b0, 8'd0, rdata);
    if (rdata[7:0] !== value) begin
      $error("wanted_code readback: expected %0d, got %0d", value, rdata[7:0]);
      mismatches++;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (tx_bytes.size() != 0 || s_axis_tvalid || pending_answers.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic put_record(input logic [7:0] code, input int len);
    area_q.push_back(code);
    area_q.push_back(8'(len));
    repeat (len) area_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_overload(input logic [1:0] bits);
    int len;
    len = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 3);
    area_q.push_back(CodeOverload);
    area_q.push_back(8'(len));
    if (len > 0) area_q.push_back({6'($urandom_range(0, 63)), bits});
    repeat (len - 1) area_q.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic int pick_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4) : $urandom_range(5, 40);
  endfunction

  function automatic logic [7:0] pick_code();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 254));
    while (c == CodeOverload);
    return c;
  endfunction

  task automatic build_area(input bit with_ovl, input logic [1:0] bits);
    int n;
    int at;
    int sel;
    area_q.delete();
    n = $urandom_range(0, 4);
    at = $urandom_range(0, n);
    for (int i = 0; i <= n; i++) begin
      if (with_ovl && i == at) put_overload(bits);
      if (i < n) begin
        sel = $urandom_range(0, 99);
        if (sel < 15) repeat ($urandom_range(1, 3)) area_q.push_back(CodePad);
        else if (sel < 45) put_record(want_code, pick_length());
        else put_record(pick_code(), pick_length());
      end
    end
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      area_q.push_back(CodeEnd);
      repeat ($urandom_range(0, 2)) area_q.push_back(8'($urandom_range(0, 255)));
    end else if (sel >= 93 && area_q.size() > 2) begin
      repeat ($urandom_range(1, 2)) void'(area_q.pop_back());
    end
    if (area_q.size() == 0) area_q.push_back(CodePad);
  endtask

  task automatic feed_area(input logic [1:0] rgn, input bit mark_end);
    item_t it;
    foreach (area_q[i]) begin
      it.opt_byte = area_q[i];
      it.region = rgn;
      it.region_last = mark_end && (i == area_q.size() - 1);
      it.packet_last = 1'b0;
      msg_q.push_back(it);
    end
  endtask

  task automatic add_noise();
    item_t it;
    it.opt_byte = 8'($urandom_range(0, 255));
    it.region = 2'd3;
    it.region_last = 1'($urandom_range(0, 1));
    it.packet_last = 1'b0;
    msg_q.insert($urandom_range(0, msg_q.size()), it);
  endtask

  task automatic post_message();
    if (msg_q.size() == 0) add_noise();
    msg_q[msg_q.size() - 1].packet_last = 1'b1;
    foreach (msg_q[i]) tx_bytes.push_back(msg_q[i]);
    queued_bytes += msg_q.size();
    msg_q.delete();
  endtask

  task automatic gen_message();
    logic [1:0] opt_bits;
    bit swap;
    int keep;
    msg_q.delete();
    opt_bits = 2'($urandom_range(0, 3));
    swap = ($urandom_range(0, 19) == 0);
    build_area(opt_bits != 0 && $urandom_range(0, 9) != 0, opt_bits);
    if ($urandom_range(0, 32) != 0) feed_area(RegionOptions, $urandom_range(0, 11) != 0);
    build_area($urandom_range(0, 3) == 0, 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 9) != 0) begin
      feed_area(swap ? RegionSname : RegionFile, $urandom_range(0, 11) != 0);
    end
    build_area($urandom_range(0, 3) == 0, 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 9) != 0) begin
      feed_area(swap ? RegionFile : RegionSname, $urandom_range(0, 11) != 0);
    end
    if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 3)) add_noise();
    if ($urandom_range(0, 12) == 0 && msg_q.size() > 1) begin
      keep = $urandom_range(1, msg_q.size());
      while (msg_q.size() > keep) void'(msg_q.pop_back());
    end
    post_message();
  endtask

  initial begin
    logic [7:0] code_plan [8];
    code_plan = '{8'd0, 8'd255, CodeOverload, 8'd1, 8'd200, 8'($urandom_range(1, 254)),
                  WantedReset, 8'($urandom_range(0, 255))};
    want_code = WantedReset;
    restart_search();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    area_q = '{8'd53, 8'd1, 8'd5, CodeEnd};
    feed_area(RegionOptions, 1'b1);
    post_message();
    area_q = '{CodePad, CodePad};
    feed_area(RegionOptions, 1'b1);
    post_message();
    area_q = '{8'd9, 8'd0, CodeEnd};
    feed_area(RegionOptions, 1'b0);
    post_message();
    area_q = '{8'd12, 8'd3, 8'd1};
    feed_area(RegionOptions, 1'b1);
    post_message();
    area_q = '{8'd53, 8'd2, 8'd7, 8'd9};
    feed_area(RegionOptions, 1'b1);
    post_message();
    area_q = '{CodeOverload, 8'd1, 8'd3, CodeEnd};
    feed_area(RegionOptions, 1'b1);
    area_q = '{8'd53, 8'd0};
    feed_area(RegionFile, 1'b1);
    add_noise();
    post_message();
    area_q = '{CodeOverload, 8'd0, CodeEnd};
    feed_area(RegionOptions, 1'b1);
    post_message();
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      src_gap_max = (ph == 0 || ph == 3 || ph == 5) ? 0 : 5;
      sink_gap_max = (ph == 0 || ph == 6) ? 0 : 5;
      set_wanted_code(code_plan[ph]);
      queued_bytes = 0;
      if (ph == 3) begin
        // One area of maximum size, closed only by the size limit, with the
        // match's data byte last so that its offset is the largest one.
        area_q.delete();
        put_record(8'd9, 255);
        while (area_q.size() < DefMaxAreaBytes - 4) begin
          if (area_q.size() + 4 <= DefMaxAreaBytes - 4) put_record(8'd7, 2);
          else area_q.push_back(CodePad);
        end
        area_q.push_back(CodePad);
        put_record(want_code, 1);
        feed_area(RegionOptions, 1'b0);
        post_message();
      end
      if (ph == 4) begin
        area_q.delete();
        put_record(want_code, 255);
        area_q.push_back(CodeEnd);
        feed_area(RegionOptions, 1'b1);
        post_message();
      end
      if (ph == 5) begin
        // Short messages against a stalled receiver fill the block up.
        hold_req = !hold_req;
        for (int k = 0; k < 12; k++) begin
          if (k % 2 == 0) area_q = '{want_code, 8'd0, CodeEnd};
          else area_q = '{CodeEnd};
          feed_area(RegionOptions, 1'b1);
          post_message();
        end
      end
      while (queued_bytes < PhaseBytes) gen_message();
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("PASS dhcp_option_find");
    end else begin
      $display("FAIL dhcp_option_find");
    end
    $finish;
  end

endmodule
